FILE: sv/dctq_pkg.sv
package dctq_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int MAX_FIRES      = 63;
    localparam int FIRE_W         = 6;

    typedef enum logic [2:0] {
        OP_PROCESS  = 3'd0,
        OP_ARM_DLY  = 3'd1,
        OP_ARM_AT   = 3'd2,
        OP_ARM_PER  = 3'd3,
        OP_CANCEL   = 3'd4,
        OP_POSTPONE = 3'd5
    } t_op;

    localparam logic KIND_FIRE  = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_POST,
        ST_SCAN,
        ST_DECIDE,
        ST_FIRE,
        ST_CLOSE
    } t_state;

    typedef struct packed {
        logic        kind;
        logic [3:0]  fired_slot;
        logic        slot_idle;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [63:0] deadline;
        logic [63:0] period;
        logic [31:0] stamp;
    } t_entry;

endpackage

FILE: sv/dctq_if.sv
interface dctq_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [3:0]  slot;
    logic [63:0] now_us;
    logic [63:0] time_value;
    logic [63:0] period_us;

    modport source(output valid, op, slot, now_us, time_value, period_us, input ready);
    modport sink(input valid, op, slot, now_us, time_value, period_us, output ready);
endinterface

interface dctq_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [3:0] fired_slot;
    logic       slot_idle;
    logic       last;

    modport source(output valid, kind, fired_slot, slot_idle, last, input ready);
    modport sink(input valid, kind, fired_slot, slot_idle, last, output ready);
endinterface

FILE: sv/dctq_slot_mem.sv
module dctq_slot_mem #(
    parameter int SLOT_COUNT = dctq_pkg::SLOT_COUNT_DEF,
    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IW-1:0]    i_waddr,
    input  dctq_pkg::t_entry i_wdata,
    input  logic [IW-1:0]    i_raddr,
    output dctq_pkg::t_entry o_rdata
);

    dctq_pkg::t_entry r_mem [SLOT_COUNT];
    dctq_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/dctq_out_reg.sv
module dctq_out_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  dctq_pkg::t_res i_res,
    output logic           o_free,
    dctq_out_if.source     o_out
);

    logic           r_valid;
    dctq_pkg::t_res r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_free           = !r_valid || o_out.ready;
    assign o_out.valid      = r_valid;
    assign o_out.kind       = r_res.kind;
    assign o_out.fired_slot = r_res.fired_slot;
    assign o_out.slot_idle  = r_res.slot_idle;
    assign o_out.last       = r_res.last;

endmodule

FILE: sv/deadline_callout_timer_queue.sv
// Deadline-ordered timer callout queue. Slot deadlines, periods and arming
// stamps sit in one single-port-read memory; armed bits are flip-flops.
// One item is taken at a time. Each fire costs one scan of the memory
// and a decide state, plus a fire state that waits while the output
// register is full. Cancel, postpone and unused ops skip the scan.
// The closing result (last set) reports whether the addressed slot is
// idle; up to 63 fires precede it.
module deadline_callout_timer_queue #(
    parameter int SLOT_COUNT = dctq_pkg::SLOT_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dctq_in_if.sink    i_in,
    dctq_out_if.source o_out
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);

    dctq_pkg::t_state r_state, n_state;

    logic [2:0]       r_op;
    logic [3:0]       r_slot;
    logic [63:0]      r_now, r_tv, r_per;
    logic [SLOT_COUNT-1:0] r_armed;
    logic [31:0]      r_counter;
    logic [CW-1:0]    r_cnt;
    logic             r_rd_act;
    logic [IW-1:0]    r_rd_idx;
    logic             r_have;
    logic [IW-1:0]    r_best_idx;
    logic [63:0]      r_best_dl, r_best_per;
    logic [31:0]      r_best_age;
    logic [dctq_pkg::FIRE_W-1:0] r_fires;

    logic             slot_ok;
    logic [IW-1:0]    slot_idx;
    logic             out_free;
    logic             out_load;
    dctq_pkg::t_res   out_res;
    logic             mem_we;
    logic [IW-1:0]    mem_waddr, mem_raddr;
    dctq_pkg::t_entry mem_wdata, mem_rdata;
    logic             is_arm;
    logic [63:0]      arm_dl;
    logic [31:0]      cand_age;
    logic             cand_due, cand_better;
    logic             issue;

    assign slot_ok  = 32'(r_slot) < SLOT_COUNT;
    assign slot_idx = IW'(r_slot);
    assign is_arm   = (r_op == dctq_pkg::OP_ARM_DLY) || (r_op == dctq_pkg::OP_ARM_AT)
                   || (r_op == dctq_pkg::OP_ARM_PER);
    assign arm_dl   = (r_op == dctq_pkg::OP_ARM_AT) ? ((r_tv > r_now) ? r_tv : r_now)
                                                    : r_now + r_tv;
    assign issue    = (r_state == dctq_pkg::ST_SCAN) && (r_cnt < CW'(SLOT_COUNT));
    assign cand_age = r_counter - mem_rdata.stamp;
    assign cand_due = r_rd_act && r_armed[r_rd_idx] && (mem_rdata.deadline <= r_now);
    assign cand_better = cand_due && (!r_have || (mem_rdata.deadline < r_best_dl)
                      || ((mem_rdata.deadline == r_best_dl) && (cand_age > r_best_age)));

    always_comb begin
        n_state = r_state;
        case (r_state)
            dctq_pkg::ST_IDLE: begin
                if (i_in.valid) n_state = dctq_pkg::ST_APPLY;
            end
            dctq_pkg::ST_APPLY: begin
                case (r_op) inside
                    dctq_pkg::OP_PROCESS, dctq_pkg::OP_ARM_DLY,
                    dctq_pkg::OP_ARM_AT, dctq_pkg::OP_ARM_PER: n_state = dctq_pkg::ST_SCAN;
                    dctq_pkg::OP_POSTPONE: begin
                        n_state = (slot_ok && r_armed[slot_idx]) ? dctq_pkg::ST_POST
                                                                 : dctq_pkg::ST_CLOSE;
                    end
                    default: n_state = dctq_pkg::ST_CLOSE;
                endcase
            end
            dctq_pkg::ST_POST:   n_state = dctq_pkg::ST_CLOSE;
            dctq_pkg::ST_SCAN: begin
                if (r_cnt == CW'(SLOT_COUNT)) n_state = dctq_pkg::ST_DECIDE;
            end
            dctq_pkg::ST_DECIDE: begin
                n_state = (!r_have || r_fires == dctq_pkg::FIRE_W'(dctq_pkg::MAX_FIRES))
                        ? dctq_pkg::ST_CLOSE : dctq_pkg::ST_FIRE;
            end
            dctq_pkg::ST_FIRE: begin
                if (out_free) n_state = dctq_pkg::ST_SCAN;
            end
            dctq_pkg::ST_CLOSE: begin
                if (out_free) n_state = dctq_pkg::ST_IDLE;
            end
            default: n_state = dctq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = slot_idx;
        mem_wdata  = '{deadline: arm_dl,
                       period: (r_op == dctq_pkg::OP_ARM_PER) ? r_per : 64'd0,
                       stamp: r_counter};
        mem_raddr  = r_cnt[IW-1:0];
        out_load   = 1'b0;
        out_res    = '{kind: dctq_pkg::KIND_CLOSE, fired_slot: 4'd0,
                       slot_idle: !(slot_ok && r_armed[slot_idx]), last: 1'b1};
        case (r_state)
            dctq_pkg::ST_IDLE:  i_in.ready = 1'b1;
            dctq_pkg::ST_APPLY: begin
                mem_we    = is_arm && slot_ok;
                mem_raddr = slot_idx;
            end
            dctq_pkg::ST_POST: begin
                mem_we    = 1'b1;
                mem_wdata = '{deadline: mem_rdata.deadline + r_tv,
                              period: mem_rdata.period, stamp: mem_rdata.stamp};
            end
            dctq_pkg::ST_FIRE: begin
                out_load  = out_free;
                out_res   = '{kind: dctq_pkg::KIND_FIRE, fired_slot: 4'(r_best_idx),
                              slot_idle: 1'b0, last: 1'b0};
                mem_we    = out_free && (r_best_per != 64'd0);
                mem_waddr = r_best_idx;
                mem_wdata = '{deadline: r_best_dl + r_best_per, period: r_best_per,
                              stamp: r_counter};
            end
            dctq_pkg::ST_CLOSE: out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dctq_pkg::ST_IDLE;
            r_armed   <= '0;
            r_counter <= 32'd0;
            r_rd_act  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_act <= issue;
            case (r_state)
                dctq_pkg::ST_APPLY: begin
                    if (is_arm && slot_ok) begin
                        r_armed[slot_idx] <= 1'b1;
                        r_counter         <= r_counter + 32'd1;
                    end else if (r_op == dctq_pkg::OP_CANCEL && slot_ok) begin
                        r_armed[slot_idx] <= 1'b0;
                    end
                end
                dctq_pkg::ST_FIRE: begin
                    if (out_free) begin
                        if (r_best_per != 64'd0) begin
                            r_counter <= r_counter + 32'd1;
                        end else begin
                            r_armed[r_best_idx] <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_op    <= i_in.op;
            r_slot  <= i_in.slot;
            r_now   <= i_in.now_us;
            r_tv    <= i_in.time_value;
            r_per   <= i_in.period_us;
            r_fires <= '0;
        end
        r_rd_idx <= r_cnt[IW-1:0];
        case (r_state)
            dctq_pkg::ST_APPLY, dctq_pkg::ST_FIRE: begin
                r_cnt  <= '0;
                r_have <= 1'b0;
                if (r_state == dctq_pkg::ST_FIRE && out_free) r_fires <= r_fires + 1'b1;
            end
            dctq_pkg::ST_SCAN: begin
                if (issue) r_cnt <= r_cnt + 1'b1;
                if (cand_better) begin
                    r_have     <= 1'b1;
                    r_best_idx <= r_rd_idx;
                    r_best_dl  <= mem_rdata.deadline;
                    r_best_per <= mem_rdata.period;
                    r_best_age <= cand_age;
                end
            end
            default: ;
        endcase
    end

    dctq_slot_mem #(.SLOT_COUNT(SLOT_COUNT)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    dctq_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_res   (out_res),
        .o_free  (out_free),
        .o_out   (o_out)
    );

    a_accept_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == dctq_pkg::ST_APPLY))
        else $error("accepted item not applied");

    a_fire_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dctq_pkg::ST_FIRE) |-> (r_fires < dctq_pkg::FIRE_W'(dctq_pkg::MAX_FIRES)))
        else $error("fire limit exceeded");

    a_fire_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && out_res.kind == dctq_pkg::KIND_FIRE) |-> !out_res.last)
        else $error("fire result marked last");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("output register overwritten");

endmodule
